/* design/scic_pkg.sv */
`default_nettype none
package scic_pkg;

    localparam int CW   = 16;
    localparam int FB   = 16;
    localparam int OW   = 48;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int NW   = PW + 1;
    localparam int MW   = NW - 1;
    localparam int PRW  = MW + DW;
    localparam int QB   = OW;
    localparam int LB   = QB - FB;
    localparam int NPTS = 8;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_PROPER  = 2'd1,
        KIND_VERTEX  = 2'd2,
        KIND_OVERLAP = 2'd3
    } kind_t;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [NW-1:0] wide_t;

    typedef struct packed {
        kind_t           kind;
        logic            use_div;
        logic            negx;
        logic            negy;
        coord_t          ax;
        coord_t          ay;
        coord_t          cpx;
        coord_t          cpy;
        logic [MW-1:0]   den;
    } side_t;

    typedef struct packed {
        logic            ovf;
        logic [MW-1:0]   rem;
        logic [QB-1:0]   low;
        logic [QB-1:0]   quo;
    } lane_t;

    function automatic diff_t sx(input coord_t c);
        return diff_t'(c);
    endfunction

    function automatic logic between(input coord_t a, input coord_t b, input coord_t v);
        return ((a <= v) && (v <= b)) || ((a >= v) && (v >= b));
    endfunction

    // r on segment pq, tested on x unless pq is vertical
    function automatic logic on_seg(input coord_t px, input coord_t py,
                                    input coord_t qx, input coord_t qy,
                                    input coord_t rx, input coord_t ry);
        logic res;
        if (px != qx)
        begin
            res = between(px, qx, rx);
        end
        else
        begin
            res = between(py, qy, ry);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* design/scic_geom.sv */
`default_nettype none
module scic_geom (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        ce,
    input  logic                                        in_valid,
    input  logic [scic_pkg::NPTS*scic_pkg::CW-1:0]      in_data,
    output logic                                        out_valid,
    output scic_pkg::side_t                             out_side,
    output scic_pkg::lane_t                             out_lane_x,
    output scic_pkg::lane_t                             out_lane_y
);
    import scic_pkg::*;

    logic [5:0]      v_reg;

    coord_t          pt_in [NPTS];
    diff_t           dif_next [6];
    coord_t          pt1_reg [NPTS];
    diff_t           dif1_reg [6];

    prod_t           prod_next [6];
    coord_t          pt2_reg [NPTS];
    diff_t           dif2_reg [2];
    prod_t           prod2_reg [6];

    wide_t           den3_next, ns3_next, nt3_next;
    wide_t           den3_reg, ns3_reg, nt3_reg;
    coord_t          pt3_reg [NPTS];
    diff_t           dif3_reg [2];

    wide_t           denn, nsn, ntn;
    logic            par;
    side_t           side4_next, side4_reg;
    logic [MW-1:0]   nsm4_next, nsm4_reg;
    logic [DW-1:0]   e1xm4_next, e1ym4_next, e1xm4_reg, e1ym4_reg;

    logic [PRW-1:0]  prx5_next, pry5_next, prx5_reg, pry5_reg;
    side_t           side5_reg;

    lane_t           lx6_next, ly6_next, lx6_reg, ly6_reg;
    side_t           side6_reg;

    // stage 1: edge and offset vectors
    always_comb
    begin
        for (int i = 0; i < NPTS; i++)
        begin
            pt_in[i] = coord_t'(in_data[i*CW +: CW]);
        end
        dif_next[0] = sx(pt_in[2]) - sx(pt_in[0]);
        dif_next[1] = sx(pt_in[3]) - sx(pt_in[1]);
        dif_next[2] = sx(pt_in[6]) - sx(pt_in[4]);
        dif_next[3] = sx(pt_in[7]) - sx(pt_in[5]);
        dif_next[4] = sx(pt_in[4]) - sx(pt_in[0]);
        dif_next[5] = sx(pt_in[5]) - sx(pt_in[1]);
    end

    // stage 2: cross products
    always_comb
    begin
        prod_next[0] = prod_t'(dif1_reg[1]) * prod_t'(dif1_reg[2]);
        prod_next[1] = prod_t'(dif1_reg[0]) * prod_t'(dif1_reg[3]);
        prod_next[2] = prod_t'(dif1_reg[5]) * prod_t'(dif1_reg[2]);
        prod_next[3] = prod_t'(dif1_reg[4]) * prod_t'(dif1_reg[3]);
        prod_next[4] = prod_t'(dif1_reg[5]) * prod_t'(dif1_reg[0]);
        prod_next[5] = prod_t'(dif1_reg[4]) * prod_t'(dif1_reg[1]);
    end

    // stage 3: denominator and numerators
    always_comb
    begin
        den3_next = wide_t'(prod2_reg[0]) - wide_t'(prod2_reg[1]);
        ns3_next  = wide_t'(prod2_reg[2]) - wide_t'(prod2_reg[3]);
        nt3_next  = wide_t'(prod2_reg[4]) - wide_t'(prod2_reg[5]);
    end

    // stage 4: sign normalise, classify, collinear point
    always_comb
    begin
        denn = den3_reg[NW-1] ? -den3_reg : den3_reg;
        nsn  = den3_reg[NW-1] ? -ns3_reg  : ns3_reg;
        ntn  = den3_reg[NW-1] ? -nt3_reg  : nt3_reg;
        par  = (den3_reg == '0);

        side4_next.use_div = !par;
        side4_next.ax      = pt3_reg[0];
        side4_next.ay      = pt3_reg[1];
        side4_next.den     = MW'(denn);
        side4_next.negx    = nsn[NW-1] != dif3_reg[0][DW-1];
        side4_next.negy    = nsn[NW-1] != dif3_reg[1][DW-1];
        side4_next.cpx     = '0;
        side4_next.cpy     = '0;
        side4_next.kind    = KIND_NONE;

        if (!par)
        begin
            if ((nsn > 0) && (nsn < denn) && (ntn > 0) && (ntn < denn))
            begin
                side4_next.kind = KIND_PROPER;
            end
            else if ((nsn < 0) || (nsn > denn) || (ntn < 0) || (ntn > denn))
            begin
                side4_next.kind = KIND_NONE;
            end
            else
            begin
                side4_next.kind = KIND_VERTEX;
            end
        end
        else if (nt3_reg == '0)
        begin
            side4_next.kind = KIND_OVERLAP;
            if (on_seg(pt3_reg[0], pt3_reg[1], pt3_reg[2], pt3_reg[3],
                       pt3_reg[4], pt3_reg[5]))
            begin
                side4_next.cpx = pt3_reg[4];
                side4_next.cpy = pt3_reg[5];
            end
            else if (on_seg(pt3_reg[0], pt3_reg[1], pt3_reg[2], pt3_reg[3],
                            pt3_reg[6], pt3_reg[7]))
            begin
                side4_next.cpx = pt3_reg[6];
                side4_next.cpy = pt3_reg[7];
            end
            else if (on_seg(pt3_reg[4], pt3_reg[5], pt3_reg[6], pt3_reg[7],
                            pt3_reg[0], pt3_reg[1]))
            begin
                side4_next.cpx = pt3_reg[0];
                side4_next.cpy = pt3_reg[1];
            end
            else if (on_seg(pt3_reg[4], pt3_reg[5], pt3_reg[6], pt3_reg[7],
                            pt3_reg[2], pt3_reg[3]))
            begin
                side4_next.cpx = pt3_reg[2];
                side4_next.cpy = pt3_reg[3];
            end
            else
            begin
                side4_next.kind = KIND_NONE;
            end
        end

        nsm4_next  = nsn[NW-1] ? MW'(-nsn) : MW'(nsn);
        e1xm4_next = dif3_reg[0][DW-1] ? DW'(-dif3_reg[0]) : DW'(dif3_reg[0]);
        e1ym4_next = dif3_reg[1][DW-1] ? DW'(-dif3_reg[1]) : DW'(dif3_reg[1]);
    end

    // stage 5: |ns| times |b-a|
    always_comb
    begin
        prx5_next = PRW'(nsm4_reg) * PRW'(e1xm4_reg);
        pry5_next = PRW'(nsm4_reg) * PRW'(e1ym4_reg);
    end

    // stage 6: overflow check and divider seed
    always_comb
    begin
        lx6_next.ovf = (PRW+LB)'(prx5_reg) >= {side5_reg.den, {LB{1'b0}}};
        lx6_next.rem = MW'(prx5_reg >> LB);
        lx6_next.low = {prx5_reg[LB-1:0], {FB{1'b0}}};
        lx6_next.quo = '0;
        ly6_next.ovf = (PRW+LB)'(pry5_reg) >= {side5_reg.den, {LB{1'b0}}};
        ly6_next.rem = MW'(pry5_reg >> LB);
        ly6_next.low = {pry5_reg[LB-1:0], {FB{1'b0}}};
        ly6_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ce)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pt1_reg     <= pt_in;
            dif1_reg    <= dif_next;
            pt2_reg     <= pt1_reg;
            dif2_reg[0] <= dif1_reg[0];
            dif2_reg[1] <= dif1_reg[1];
            prod2_reg   <= prod_next;
            pt3_reg     <= pt2_reg;
            dif3_reg    <= dif2_reg;
            den3_reg    <= den3_next;
            ns3_reg     <= ns3_next;
            nt3_reg     <= nt3_next;
            side4_reg   <= side4_next;
            nsm4_reg    <= nsm4_next;
            e1xm4_reg   <= e1xm4_next;
            e1ym4_reg   <= e1ym4_next;
            side5_reg   <= side4_reg;
            prx5_reg    <= prx5_next;
            pry5_reg    <= pry5_next;
            side6_reg   <= side5_reg;
            lx6_reg     <= lx6_next;
            ly6_reg     <= ly6_next;
        end
    end

    assign out_valid  = v_reg[5];
    assign out_side   = side6_reg;
    assign out_lane_x = lx6_reg;
    assign out_lane_y = ly6_reg;

endmodule
`default_nettype wire

/* design/scic_div.sv */
`default_nettype none
module scic_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  scic_pkg::side_t   in_side,
    input  scic_pkg::lane_t   in_lane_x,
    input  scic_pkg::lane_t   in_lane_y,
    output logic              out_valid,
    output scic_pkg::side_t   out_side,
    output scic_pkg::lane_t   out_lane_x,
    output scic_pkg::lane_t   out_lane_y
);
    import scic_pkg::*;

    // one restoring quotient bit per stage
    function automatic lane_t step(input lane_t l, input logic [MW-1:0] den);
        logic [MW:0] t;
        logic        ge;
        lane_t       o;
        t     = {l.rem, l.low[QB-1]};
        ge    = t >= {1'b0, den};
        o.ovf = l.ovf;
        o.rem = ge ? MW'(t - {1'b0, den}) : MW'(t);
        o.low = {l.low[QB-2:0], 1'b0};
        o.quo = {l.quo[QB-2:0], ge};
        return o;
    endfunction

    logic [QB-1:0] v_reg;
    side_t         side_reg [QB];
    lane_t         lx_reg [QB];
    lane_t         ly_reg [QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ce)
        begin
            v_reg <= {v_reg[QB-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side_reg[0] <= in_side;
            lx_reg[0]   <= step(in_lane_x, in_side.den);
            ly_reg[0]   <= step(in_lane_y, in_side.den);
        end
    end

    for (genvar k = 1; k < QB; k++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                side_reg[k] <= side_reg[k-1];
                lx_reg[k]   <= step(lx_reg[k-1], side_reg[k-1].den);
                ly_reg[k]   <= step(ly_reg[k-1], side_reg[k-1].den);
            end
        end
    end

    assign out_valid  = v_reg[QB-1];
    assign out_side   = side_reg[QB-1];
    assign out_lane_x = lx_reg[QB-1];
    assign out_lane_y = ly_reg[QB-1];

endmodule
`default_nettype wire

/* design/scic_out.sv */
`default_nettype none
module scic_out (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     ce,
    input  logic                     in_valid,
    input  scic_pkg::side_t          in_side,
    input  scic_pkg::lane_t          in_lane_x,
    input  scic_pkg::lane_t          in_lane_y,
    output logic                     out_valid,
    output scic_pkg::kind_t          out_kind,
    output logic [scic_pkg::OW-1:0]  out_px,
    output logic [scic_pkg::OW-1:0]  out_py
);
    import scic_pkg::*;

    localparam logic signed [OW+1:0] OMAX = (OW+2)'((64'sd1 <<< (OW - 1)) - 64'sd1);
    localparam logic signed [OW+1:0] OMIN = -OMAX - (OW+2)'(1);

    // round to nearest, add base, saturate
    function automatic logic [OW-1:0] finish(input lane_t l, input logic [MW-1:0] den,
                                             input logic neg, input coord_t c);
        logic                 rnd;
        logic [QB:0]          qr;
        logic signed [OW+1:0] base;
        logic signed [OW+1:0] sum;
        logic [OW-1:0]        res;
        rnd  = {l.rem, 1'b0} >= {1'b0, den};
        qr   = (QB+1)'(l.quo) + (QB+1)'(rnd);
        base = (OW+2)'(c) <<< FB;
        sum  = neg ? base - signed'({1'b0, qr}) : base + signed'({1'b0, qr});
        if (l.ovf)
        begin
            res = neg ? OMIN[OW-1:0] : OMAX[OW-1:0];
        end
        else if (sum > OMAX)
        begin
            res = OMAX[OW-1:0];
        end
        else if (sum < OMIN)
        begin
            res = OMIN[OW-1:0];
        end
        else
        begin
            res = sum[OW-1:0];
        end
        return res;
    endfunction

    logic          valid_reg;
    kind_t         kind_reg;
    logic [OW-1:0] px_reg, py_reg;
    logic [OW-1:0] px_next, py_next;

    always_comb
    begin
        if (in_side.use_div)
        begin
            px_next = finish(in_lane_x, in_side.den, in_side.negx, in_side.ax);
            py_next = finish(in_lane_y, in_side.den, in_side.negy, in_side.ay);
        end
        else
        begin
            px_next = OW'(in_side.cpx) <<< FB;
            py_next = OW'(in_side.cpy) <<< FB;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            kind_reg <= in_side.kind;
            px_reg   <= px_next;
            py_reg   <= py_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_px    = px_reg;
    assign out_py    = py_reg;

endmodule
`default_nettype wire

/* design/segment_intersection_classify_core.sv */
// Segment pair intersection classifier.
// Input channel s_*: one item is a pair of segments ab, cd with 16-bit signed
// endpoints, taken when s_tvalid and s_tready are high at a rising edge.
// Output channel m_*: one item per input item, in order; m_tuser carries the
// kind (none, proper, vertex, collinear overlap), m_tdata the meeting point
// in signed fixed point with 16 fraction bits, saturated to 48 bits.
// The pipeline has 6 geometry stages (differences, cross products,
// numerators, classification, scaling product, divider seed), 48 stages of
// the restoring divider, one bit per stage for x and y side by side, and the
// rounding/saturation output register.
// Throughput is one item per cycle while the output is not stalled.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated. A new item is still taken in
// a cycle where the waiting result leaves.
// rst_n clears all valid bits asynchronously; the block then accepts at once.
`default_nettype none
module segment_intersection_classify_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // ax, ay, bx, by, cx, cy, dx, dy (16 bits each)
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // px [47:0], py [95:48], zero pad
    output logic [1:0]   m_tuser    // kind
);
    import scic_pkg::*;

    logic          ce;
    logic          g_valid, d_valid;
    side_t         g_side, d_side;
    lane_t         g_lx, g_ly, d_lx, d_ly;
    kind_t         kind;
    logic [OW-1:0] px, py;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    scic_geom u_geom (
        .clk        (clk),
        .rst_n      (rst_n),
        .ce         (ce),
        .in_valid   (s_tvalid),
        .in_data    (s_tdata),
        .out_valid  (g_valid),
        .out_side   (g_side),
        .out_lane_x (g_lx),
        .out_lane_y (g_ly)
    );

    scic_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .ce         (ce),
        .in_valid   (g_valid),
        .in_side    (g_side),
        .in_lane_x  (g_lx),
        .in_lane_y  (g_ly),
        .out_valid  (d_valid),
        .out_side   (d_side),
        .out_lane_x (d_lx),
        .out_lane_y (d_ly)
    );

    scic_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (d_valid),
        .in_side   (d_side),
        .in_lane_x (d_lx),
        .in_lane_y (d_ly),
        .out_valid (m_tvalid),
        .out_kind  (kind),
        .out_px    (px),
        .out_py    (py)
    );

    assign m_tdata = {8'b0, py, px};
    assign m_tuser = kind;

endmodule
`default_nettype wire

/* design/scic_checker.sv */
`default_nettype none
module scic_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic [1:0]   m_tuser
);
    import scic_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> s_tready == (!m_tvalid || m_tready))
        else $error("input ready not tied to output slot");

    a_overlap_int: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_OVERLAP |->
            m_tdata[FB-1:0] == '0 && m_tdata[OW+FB-1:OW] == '0)
        else $error("overlap point not on integer grid");

endmodule

bind segment_intersection_classify_core scic_checker u_scic_checker (.*);
`default_nettype wire

/* test/segment_intersection_classify_core_tb.sv */
module segment_intersection_classify_core_tb;
    import scic_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [47:0] px;
        logic [47:0] py;
    } meet_t;

    class meet_scoreboard;
        meet_t  awaited[$];
        int     errors;
        int     seen;
        int     kinds[4];

        function longint fix_coord(longint base, longint num, longint diff, longint den);
            logic [127:0] prod;
            logic [127:0] quo;
            logic [127:0] rem;
            longint       q;
            longint       v;
            longint       lim;
            prod = 128'(num < 0 ? -num : num) * 128'(diff < 0 ? -diff : diff);
            prod = prod << FB;
            quo  = prod / 128'(den);
            rem  = prod % 128'(den);
            if (quo > (128'(1) << 62))
            begin
                q = longint'(1) << 62;
            end
            else
            begin
                q = longint'(quo[63:0]) + ((2 * rem >= 128'(den)) ? 1 : 0);
            end
            v   = ((num < 0) != (diff < 0)) ? base * 65536 - q : base * 65536 + q;
            lim = (longint'(1) << (OW - 1)) - 1;
            if (v > lim)
            begin
                v = lim;
            end
            else if (v < -lim - 1)
            begin
                v = -lim - 1;
            end
            return v;
        endfunction

        function bit lies_on(longint px, longint py, longint qx, longint qy,
                             longint rx, longint ry);
            if (px != qx)
            begin
                return (px <= rx && rx <= qx) || (px >= rx && rx >= qx);
            end
            return (py <= ry && ry <= qy) || (py >= ry && ry >= qy);
        endfunction

        function meet_t classify_pair(logic [127:0] d);
            coord_t t;
            longint c[8];
            longint den;
            longint ns;
            longint nt;
            longint px;
            longint py;
            meet_t  m;
            for (int i = 0; i < 8; i++)
            begin
                t    = d[16*i +: 16];
                c[i] = t;
            end
            px     = 0;
            py     = 0;
            m.kind = KIND_NONE;
            den = c[0] * (c[7] - c[5]) + c[2] * (c[5] - c[7])
                + c[6] * (c[3] - c[1]) + c[4] * (c[1] - c[3]);
            if (den == 0)
            begin
                if ((c[2] - c[0]) * (c[5] - c[1]) - (c[4] - c[0]) * (c[3] - c[1]) == 0)
                begin
                    m.kind = KIND_OVERLAP;
                    if (lies_on(c[0], c[1], c[2], c[3], c[4], c[5]))
                    begin
                        px = c[4]; py = c[5];
                    end
                    else if (lies_on(c[0], c[1], c[2], c[3], c[6], c[7]))
                    begin
                        px = c[6]; py = c[7];
                    end
                    else if (lies_on(c[4], c[5], c[6], c[7], c[0], c[1]))
                    begin
                        px = c[0]; py = c[1];
                    end
                    else if (lies_on(c[4], c[5], c[6], c[7], c[2], c[3]))
                    begin
                        px = c[2]; py = c[3];
                    end
                    else
                    begin
                        m.kind = KIND_NONE;
                    end
                    px = px * 65536;
                    py = py * 65536;
                end
            end
            else
            begin
                ns = c[0] * (c[7] - c[5]) + c[4] * (c[1] - c[7]) + c[6] * (c[5] - c[1]);
                nt = -(c[0] * (c[5] - c[3]) + c[2] * (c[1] - c[5]) + c[4] * (c[3] - c[1]));
                if (den < 0)
                begin
                    den = -den; ns = -ns; nt = -nt;
                end
                m.kind = KIND_VERTEX;
                if (ns > 0 && ns < den && nt > 0 && nt < den)
                begin
                    m.kind = KIND_PROPER;
                end
                else if (ns < 0 || ns > den || nt < 0 || nt > den)
                begin
                    m.kind = KIND_NONE;
                end
                px = fix_coord(c[0], ns, c[2] - c[0], den);
                py = fix_coord(c[1], ns, c[3] - c[1], den);
            end
            m.px = px[47:0];
            m.py = py[47:0];
            return m;
        endfunction

        function void note_pair(logic [127:0] d);
            awaited.push_back(classify_pair(d));
        endfunction

        function void check_meet(logic [1:0] kind, logic [47:0] px, logic [47:0] py);
            meet_t e;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected item kind=%0d px=%h py=%h", $time, kind, px, py);
                errors++;
                return;
            end
            e = awaited.pop_front();
            seen++;
            kinds[e.kind]++;
            if (kind !== e.kind)
            begin
                $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
                errors++;
            end
            if (px !== e.px)
            begin
                $display("%0t: px expected %h actual %h", $time, e.px, px);
                errors++;
            end
            if (py !== e.py)
            begin
                $display("%0t: py expected %h actual %h", $time, e.py, py);
                errors++;
            end
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;

    int  tx_idle = 11;
    int  rx_idle = 79;
    bit  hold = 0;
    meet_scoreboard sb = new();

    segment_intersection_classify_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        m_tready <= !hold && ($urandom_range(99) >= rx_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_meet(m_tuser, m_tdata[47:0], m_tdata[95:48]);
        end
    end

    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_pair(input logic [127:0] d);
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        do
        begin
            @(posedge clk);
        end
        while (!(s_tvalid && s_tready));
        sb.note_pair(d);
        @(negedge clk);
    endtask

    function automatic logic [127:0] pack_pair(int ax, int ay, int bx, int by,
                                               int cx, int cy, int dx, int dy);
        return {dy[15:0], dx[15:0], cy[15:0], cx[15:0], by[15:0], bx[15:0], ay[15:0], ax[15:0]};
    endfunction

    function automatic int rnd(int r);
        return $urandom_range(2 * r) - r;
    endfunction

    function automatic logic [127:0] random_pair();
        int ax, ay, bx, by, cx, cy, dx, dy, ux, uy, sel;
        sel = $urandom_range(9);
        ax = rnd(40); ay = rnd(40); bx = rnd(40); by = rnd(40);
        cx = rnd(40); cy = rnd(40); dx = rnd(40); dy = rnd(40);
        case (sel)
            0, 1: return {$urandom, $urandom, $urandom, $urandom};
            2:
            begin
                ux = rnd(3); uy = rnd(3);
                bx = ax + ux * rnd(10); by = ay + uy * rnd(10);
                cx = ax + ux * rnd(10); cy = ay + uy * rnd(10);
                dx = ax + ux * rnd(10); dy = ay + uy * rnd(10);
            end
            3:
            begin
                cx = $urandom_range(1) ? ax : bx; cy = $urandom_range(1) ? ay : by;
            end
            4:
            begin
                ux = rnd(32767); uy = rnd(32767);
                bx = ux + rnd(2); by = uy + rnd(2); dx = -ux; dy = -uy; cx = rnd(2); cy = rnd(2);
                ax = -bx; ay = -by;
            end
            5:
            begin
                bx = rnd(32767); by = rnd(32767); ax = -bx; ay = -by;
                cx = rnd(32767); cy = rnd(32767); dx = -cx; dy = -cy;
            end
            default: ;
        endcase
        return pack_pair(ax, ay, bx, by, cx, cy, dx, dy);
    endfunction

    task automatic send_phase(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_pair(random_pair());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        send_pair(pack_pair(0, 0, 10, 10, 0, 10, 10, 0));
        send_pair(pack_pair(0, 0, 10, 0, 5, 0, 5, 7));
        send_pair(pack_pair(0, 0, 10, 0, 10, 0, 10, 5));
        send_pair(pack_pair(0, 0, 4, 0, 6, -3, 6, 3));
        send_pair(pack_pair(0, 0, 10, 0, 0, 1, 10, 1));
        send_pair(pack_pair(0, 0, 10, 0, 5, 0, 20, 0));
        send_pair(pack_pair(0, 0, 10, 0, -5, 0, 3, 0));
        send_pair(pack_pair(0, 0, 10, 0, -5, 0, 20, 0));
        send_pair(pack_pair(0, 0, 10, 0, 11, 0, 20, 0));
        send_pair(pack_pair(3, 0, 3, 10, 3, 5, 3, 20));
        send_pair(pack_pair(3, 0, 3, 10, 3, 11, 3, 20));
        send_pair(pack_pair(2, 2, 2, 2, 2, 2, 2, 2));
        send_pair(pack_pair(2, 2, 2, 2, 3, 3, 3, 3));
        send_pair(pack_pair(0, 0, 1, 3, 0, 1, 3, 0));
        send_pair(pack_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(pack_pair(-32768, -32768, 32767, 32767, 0, 1, 1, 2));
        send_pair(pack_pair(-32768, 32767, 32767, -32768, 32767, -32767, -32768, 32766));
        send_pair(pack_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
        send_pair(pack_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        send_pair(pack_pair(0, 0, 32767, 1, 0, 1, 32767, 2));
        send_pair({128{1'b1}});
        send_pair('0);
        send_phase(380);
        tx_idle = 79; rx_idle = 11;
        send_phase(380);
        tx_idle = 0; rx_idle = 0;
        fork
            begin
                hold = 1;
                repeat (300) @(posedge clk);
                hold = 0;
            end
            send_phase(420);
        join
        s_tvalid <= 0;
        while (sb.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
        $display("Checked %0d items: none %0d, proper %0d, vertex %0d, overlap %0d,",
                 sb.seen, sb.kinds[0], sb.kinds[1], sb.kinds[2], sb.kinds[3]);
        $display("with random stalls on both sides and a long output hold-off.");
        if (sb.errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

/* sim.f */
design/scic_pkg.sv
design/scic_geom.sv
design/scic_div.sv
design/scic_out.sv
design/segment_intersection_classify_core.sv
design/scic_checker.sv
test/segment_intersection_classify_core_tb.sv
